// ===== hdl/svpc_pkg.sv =====
// ----------------------------------------------------------------------------
// svpc_pkg
// Shared widths, fixed-point coefficients and limits for the servo position
// PI controller.
// ----------------------------------------------------------------------------
package svpc_pkg;

  localparam int POS_W   = 10;
  localparam int ANGLE_W = 8;
  localparam int FRAC_W  = 20;
  localparam int ACC_W   = 40;

  typedef logic [POS_W-1:0]          pos_t;
  typedef logic [ANGLE_W-1:0]        angle_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [31:0]        coef_t;

  typedef enum logic [1:0] {
    SEG_LINEAR,
    SEG_CUBIC,
    SEG_QUADRATIC
  } seg_t;

  // Segment boundaries in degrees
  localparam angle_t SEG1_LAST  = 8'd60;
  localparam angle_t SEG3_FIRST = 8'd100;

  // Q20 coefficients, signs folded in
  localparam coef_t S1_C1 = 32'sd7171736;
  localparam coef_t S1_C0 = 32'sd48118104;
  localparam coef_t S2_C3 = 32'sd2726;
  localparam coef_t S2_C2 = -32'sd657457;
  localparam coef_t S2_C1 = 32'sd54071919;
  localparam coef_t S2_C0 = -32'sd980775076;
  localparam coef_t S3_C2 = -32'sd47920;
  localparam coef_t S3_C1 = 32'sd19394462;
  localparam coef_t S3_C0 = -32'sd938244833;

  localparam acc_t HALF_LSB = acc_t'(1) <<< (FRAC_W - 1);

  localparam pos_t DUTY_MAX  = 10'd1023;
  localparam pos_t INTEG_MAX = 10'd1023;
  localparam pos_t ERR_LIMIT = 10'd255;
  localparam pos_t ERR_STEP1 = 10'd100;
  localparam pos_t ERR_STEP2 = 10'd200;

  // Cycles for the reference pipeline to refill after reset or a new angle
  localparam logic [2:0] SETTLE_CYCLES = 3'd4;

endpackage

// ===== hdl/svpc_if.sv =====
// ----------------------------------------------------------------------------
// svpc_if
// Valid/ready channels of the servo controller: configuration, position
// samples and drive results.
// ----------------------------------------------------------------------------
interface svpc_cfg_if import svpc_pkg::*;;
  logic   valid;
  logic   ready;
  angle_t target_angle;

  modport source (output valid, target_angle, input ready);
  modport sink   (input valid, target_angle, output ready);
endinterface

interface svpc_sample_if import svpc_pkg::*;;
  logic valid;
  logic ready;
  pos_t position_sample;

  modport source (output valid, position_sample, input ready);
  modport sink   (input valid, position_sample, output ready);
endinterface

interface svpc_result_if import svpc_pkg::*;;
  logic valid;
  logic ready;
  logic direction_pin;
  pos_t pwm_duty;

  modport source (output valid, direction_pin, pwm_duty, input ready);
  modport sink   (input valid, direction_pin, pwm_duty, output ready);
endinterface

// ===== hdl/svpc_ref_calc.sv =====
// ----------------------------------------------------------------------------
// svpc_ref_calc
// Five-stage pipeline evaluating the piecewise reference polynomial of the
// target angle in Q20, rounded half up and clamped to 0..1023.
// ----------------------------------------------------------------------------
module svpc_ref_calc import svpc_pkg::*; (
  input  logic   clk,
  input  angle_t angle,
  output pos_t   ref_pos
);

  seg_t  seg;
  coef_t c3_sel, c2_sel, c1_sel, c0_sel;

  // stage 1
  angle_t          a1;
  logic [15:0]     sq1;
  acc_t            lin1;
  coef_t           c3_1, c2_1, c0_1;
  // stage 2
  logic [23:0]     cube2;
  acc_t            quad2, lin2;
  coef_t           c3_2, c0_2;
  // stage 3
  acc_t            cubic3, part3;
  // stage 4
  acc_t            v4;
  logic [ACC_W-FRAC_W-1:0] whole4;

  always_comb begin
    if (angle <= SEG1_LAST) begin
      seg = SEG_LINEAR;
    end else if (angle < SEG3_FIRST) begin
      seg = SEG_CUBIC;
    end else begin
      seg = SEG_QUADRATIC;
    end
  end

  always_comb begin
    unique case (seg)
      SEG_LINEAR: begin
        c3_sel = '0;    c2_sel = '0;    c1_sel = S1_C1; c0_sel = S1_C0;
      end
      SEG_CUBIC: begin
        c3_sel = S2_C3; c2_sel = S2_C2; c1_sel = S2_C1; c0_sel = S2_C0;
      end
      SEG_QUADRATIC: begin
        c3_sel = '0;    c2_sel = S3_C2; c1_sel = S3_C1; c0_sel = S3_C0;
      end
      default: begin
        c3_sel = '0;    c2_sel = '0;    c1_sel = '0;    c0_sel = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    a1     <= angle;
    sq1    <= 16'(angle * angle);
    lin1   <= acc_t'(c1_sel) * acc_t'({1'b0, angle});
    c3_1   <= c3_sel;
    c2_1   <= c2_sel;
    c0_1   <= c0_sel;

    cube2  <= 24'(sq1 * a1);
    quad2  <= acc_t'(c2_1) * acc_t'({1'b0, sq1});
    lin2   <= lin1;
    c3_2   <= c3_1;
    c0_2   <= c0_1;

    cubic3 <= acc_t'(c3_2) * acc_t'({1'b0, cube2});
    part3  <= acc_t'(c0_2) + lin2 + quad2;

    v4     <= cubic3 + part3 + HALF_LSB;
  end

  assign whole4 = v4[ACC_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (v4 < 0) begin
      ref_pos <= '0;
    end else if (whole4 > (ACC_W-FRAC_W)'(DUTY_MAX)) begin
      ref_pos <= DUTY_MAX;
    end else begin
      ref_pos <= whole4[POS_W-1:0];
    end
  end

endmodule

// ===== hdl/svpc_pi_core.sv =====
// ----------------------------------------------------------------------------
// svpc_pi_core
// Sample register, error/integral/drive logic and result register. One sample
// per cycle unless held off or stalled; samples equal to the ref are dropped.
// ----------------------------------------------------------------------------
module svpc_pi_core import svpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept_en,
  input  pos_t                 ref_pos,
  svpc_sample_if.sink          sample,
  svpc_result_if.source        result
);

  logic        s1_valid;
  pos_t        s1_sample;
  logic        advance;

  logic        out_valid;
  logic        out_dir_pin;
  pos_t        out_duty;

  pos_t        integ;
  logic        last_dir;

  logic        higher;
  logic        equal;
  pos_t        err;
  logic [1:0]  quot;
  logic [POS_W:0]   integ_sum;
  pos_t        integ_next;
  logic [POS_W+2:0] drive_sum;
  pos_t        drive;
  pos_t        duty;

  assign advance      = s1_valid && (!out_valid || result.ready);
  assign sample.ready = accept_en && (!s1_valid || advance);

  assign result.valid         = out_valid;
  assign result.direction_pin = out_dir_pin;
  assign result.pwm_duty      = out_duty;

  always_comb begin
    higher = s1_sample > ref_pos;
    equal  = s1_sample == ref_pos;
    err    = higher ? (s1_sample - ref_pos) : (ref_pos - s1_sample);

    if (err >= ERR_STEP2) begin
      quot = 2'd2;
    end else if (err >= ERR_STEP1) begin
      quot = 2'd1;
    end else begin
      quot = 2'd0;
    end

    integ_sum = {1'b0, integ} + {{(POS_W-1){1'b0}}, quot};

    if (higher != last_dir) begin
      integ_next = '0;
    end else if (err < ERR_LIMIT) begin
      integ_next = (integ_sum > {1'b0, INTEG_MAX}) ? INTEG_MAX : integ_sum[POS_W-1:0];
    end else begin
      integ_next = integ;
    end

    drive_sum = {1'b0, err, 2'b00} + {3'b000, integ_next};
    drive     = (drive_sum > {3'b000, DUTY_MAX}) ? DUTY_MAX : drive_sum[POS_W-1:0];
    duty      = higher ? drive : (DUTY_MAX - drive);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      integ     <= '0;
      last_dir  <= 1'b1;
    end else begin
      if (sample.valid && sample.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end

      if (advance) begin
        out_valid <= !equal;
        if (!equal) begin
          integ    <= integ_next;
          last_dir <= higher;
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_sample <= sample.position_sample;
    end
    if (advance && !equal) begin
      out_dir_pin <= !higher;
      out_duty    <= duty;
    end
  end

endmodule

// ===== hdl/servo_position_pi_control.sv =====
// ----------------------------------------------------------------------------
// servo_position_pi_control
// Servo PI position controller with sign-magnitude PWM command output.
// A sample passes the sample register, then the result register. One sample
// per cycle unless held off or stalled; input and result registers decouple.
// Reset: integral 0, last direction 1, angle 0; samples held off after reset
//   and after each angle write while the reference pipeline refills.
// ----------------------------------------------------------------------------
module servo_position_pi_control import svpc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  svpc_cfg_if.sink        cfg,
  svpc_sample_if.sink     sample,
  svpc_result_if.source   result
);

  angle_t     target_angle;
  logic [2:0] settle;
  pos_t       ref_pos;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_angle <= '0;
      settle       <= SETTLE_CYCLES;
    end else begin
      if (cfg.valid && cfg.ready) begin
        target_angle <= cfg.target_angle;
        settle       <= SETTLE_CYCLES;
      end else if (settle != '0) begin
        settle <= settle - 3'd1;
      end
    end
  end

  svpc_ref_calc u_ref_calc (
    .clk     (clk),
    .angle   (target_angle),
    .ref_pos (ref_pos)
  );

  svpc_pi_core u_pi_core (
    .clk       (clk),
    .rst       (rst),
    .accept_en (settle == '0),
    .ref_pos   (ref_pos),
    .sample    (sample),
    .result    (result)
  );

endmodule

// ===== hdl/svpc_checker.sv =====
// ----------------------------------------------------------------------------
// svpc_checker
// Port-level checks for the servo controller, bound to the top level.
// ----------------------------------------------------------------------------
module svpc_checker import svpc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic cfg_valid,
  input logic cfg_ready,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_dir_pin,
  input pos_t out_duty
);

  // new angle blocks samples until the reference is rebuilt
  a_cfg_holds_off: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> !in_ready)
    else $error("sample accepted right after angle write");

  a_reset_holds_off: assert property (@(posedge clk)
    $fell(rst) |-> !in_ready)
    else $error("sample accepted before reference settled");

  a_result_from_transfer: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a preceding sample transfer");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_dir_pin) && $stable(out_duty)))
    else $error("stalled result changed");

endmodule

bind servo_position_pi_control svpc_checker u_svpc_checker (
  .clk         (clk),
  .rst         (rst),
  .cfg_valid   (cfg.valid),
  .cfg_ready   (cfg.ready),
  .in_valid    (sample.valid),
  .in_ready    (sample.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .out_dir_pin (result.direction_pin),
  .out_duty    (result.pwm_duty)
);
